// File: design/sppg_pkg.sv
// ----------------------------------------------------------------------------
// sppg_pkg: shared types, constants and arithmetic helpers
// Shape kinds, element kinds, point selectors, element sequence tables and the
// fixed-point kappa multiply and Q.9 to Q.8 saturating round.
// ----------------------------------------------------------------------------
package sppg_pkg;

    // Coordinate range and kappa precision
    localparam int COORD_BITS      = 32;
    localparam int KAPPA_FRAC_BITS = 16;
    localparam int SAT_BITS        = (COORD_BITS > 32) ? 32 : COORD_BITS;

    // Field widths
    localparam int PT_BITS  = 32;   // output coordinate field
    localparam int RAD_BITS = 31;   // unsigned span / radius field
    localparam int WIDE     = 36;   // internal Q.9 working width, holds every sum

    // Element sequencing
    localparam int NUM_SEL   = 6;
    localparam int SEL_BITS  = $clog2(NUM_SEL);
    localparam int MAX_ELEMS = 16;
    localparam int IDX_BITS  = $clog2(MAX_ELEMS);
    localparam int NUM_OPS   = 4;

    // Queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_BITS  = $clog2(Q_DEPTH);
    localparam int QCNT_BITS  = $clog2(Q_DEPTH + 1);

    // kappa = 0.5522847498 held at 24 fraction bits, rounded to KAPPA_FRAC_BITS
    localparam logic [63:0] KAPPA_Q24 = 64'd9265801;
    localparam logic [63:0] KAPPA_WIDE =
        ((KAPPA_Q24 << KAPPA_FRAC_BITS) + (64'd1 << 23)) >> 24;
    localparam logic [KAPPA_FRAC_BITS-1:0] KAPPA = KAPPA_WIDE[KAPPA_FRAC_BITS-1:0];

    // Saturation limits in working width
    localparam logic signed [WIDE-1:0] SAT_HI =
        WIDE'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE-1:0] SAT_LO = -SAT_HI - WIDE'(1);
    localparam logic signed [WIDE-1:0] ONE_W  = WIDE'(1);

    typedef enum logic [1:0] {
        OP_RECT    = 2'd0,
        OP_RRECT   = 2'd1,
        OP_ELLIPSE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CURVE = 2'd2,
        KIND_CTRL  = 2'd3
    } t_kind;

    // Point selectors, per axis:
    //   LO      left / top edge
    //   LO_IN   low edge plus radius minus kappa offset
    //   LO_RAD  low edge plus radius
    //   HI_RAD  high edge minus radius
    //   HI_IN   high edge minus radius plus kappa offset
    //   HI      right / bottom edge
    // For an ellipse the radius is the half span, so LO_RAD and HI_RAD both
    // land on the centre.
    localparam logic [SEL_BITS-1:0] SEL_LO     = SEL_BITS'(0);
    localparam logic [SEL_BITS-1:0] SEL_LO_IN  = SEL_BITS'(1);
    localparam logic [SEL_BITS-1:0] SEL_LO_RAD = SEL_BITS'(2);
    localparam logic [SEL_BITS-1:0] SEL_HI_RAD = SEL_BITS'(3);
    localparam logic [SEL_BITS-1:0] SEL_HI_IN  = SEL_BITS'(4);
    localparam logic [SEL_BITS-1:0] SEL_HI     = SEL_BITS'(5);

    typedef struct packed {
        t_kind               kind;
        logic [SEL_BITS-1:0] xs;
        logic [SEL_BITS-1:0] ys;
    } t_step;

    // Work item handed from front to back: shape kind and saturated Q.8 points
    typedef struct packed {
        t_op                             op;
        logic [NUM_SEL-1:0][PT_BITS-1:0] px;
        logic [NUM_SEL-1:0][PT_BITS-1:0] py;
    } t_job;

    localparam t_step PAD = '{KIND_MOVE, SEL_LO, SEL_LO};

    localparam logic [IDX_BITS-1:0] LAST_IDX [NUM_OPS] = '{
        IDX_BITS'(4), IDX_BITS'(15), IDX_BITS'(13), IDX_BITS'(0)
    };

    localparam t_step STEP_TAB [NUM_OPS][MAX_ELEMS] = '{
        // rectangle
        '{ '{KIND_MOVE,  SEL_LO,     SEL_LO},
           '{KIND_LINE,  SEL_HI,     SEL_LO},
           '{KIND_LINE,  SEL_HI,     SEL_HI},
           '{KIND_LINE,  SEL_LO,     SEL_HI},
           '{KIND_LINE,  SEL_LO,     SEL_LO},
           PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD },
        // rounded rectangle
        '{ '{KIND_MOVE,  SEL_LO,     SEL_LO_RAD},
           '{KIND_CURVE, SEL_LO,     SEL_LO_IN},
           '{KIND_CTRL,  SEL_LO_IN,  SEL_LO},
           '{KIND_CTRL,  SEL_LO_RAD, SEL_LO},
           '{KIND_LINE,  SEL_HI_RAD, SEL_LO},
           '{KIND_CURVE, SEL_HI_IN,  SEL_LO},
           '{KIND_CTRL,  SEL_HI,     SEL_LO_IN},
           '{KIND_CTRL,  SEL_HI,     SEL_LO_RAD},
           '{KIND_LINE,  SEL_HI,     SEL_HI_RAD},
           '{KIND_CURVE, SEL_HI,     SEL_HI_IN},
           '{KIND_CTRL,  SEL_HI_IN,  SEL_HI},
           '{KIND_CTRL,  SEL_HI_RAD, SEL_HI},
           '{KIND_LINE,  SEL_LO_RAD, SEL_HI},
           '{KIND_CURVE, SEL_LO_IN,  SEL_HI},
           '{KIND_CTRL,  SEL_LO,     SEL_HI_IN},
           '{KIND_CTRL,  SEL_LO,     SEL_HI_RAD} },
        // ellipse
        '{ '{KIND_MOVE,  SEL_HI,     SEL_LO_RAD},
           '{KIND_CURVE, SEL_HI,     SEL_LO_IN},
           '{KIND_CTRL,  SEL_HI_IN,  SEL_LO},
           '{KIND_CTRL,  SEL_LO_RAD, SEL_LO},
           '{KIND_CURVE, SEL_LO_IN,  SEL_LO},
           '{KIND_CTRL,  SEL_LO,     SEL_LO_IN},
           '{KIND_CTRL,  SEL_LO,     SEL_LO_RAD},
           '{KIND_CURVE, SEL_LO,     SEL_HI_IN},
           '{KIND_CTRL,  SEL_LO_IN,  SEL_HI},
           '{KIND_CTRL,  SEL_LO_RAD, SEL_HI},
           '{KIND_CURVE, SEL_HI_IN,  SEL_HI},
           '{KIND_CTRL,  SEL_HI,     SEL_HI_IN},
           '{KIND_CTRL,  SEL_HI,     SEL_LO_RAD},
           '{KIND_LINE,  SEL_HI,     SEL_LO_RAD},
           PAD, PAD },
        // unused shape code: no elements
        '{ PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD,
           PAD, PAD, PAD, PAD, PAD, PAD, PAD, PAD }
    };

    // radius times kappa, rounded to nearest with ties up
    function automatic logic [RAD_BITS-1:0] kap_mul(input logic [RAD_BITS-1:0] rad);
        logic [RAD_BITS+KAPPA_FRAC_BITS-1:0] prod;
        prod = (RAD_BITS + KAPPA_FRAC_BITS)'(rad) * (RAD_BITS + KAPPA_FRAC_BITS)'(KAPPA)
             + ((RAD_BITS + KAPPA_FRAC_BITS)'(1) << (KAPPA_FRAC_BITS - 1));
        return prod[KAPPA_FRAC_BITS +: RAD_BITS];
    endfunction

    // Q.9 to Q.8, half toward plus infinity, then clamp
    function automatic logic [PT_BITS-1:0] sat_q8(input logic signed [WIDE-1:0] v9);
        logic signed [WIDE-1:0] t;
        logic signed [WIDE-1:0] c;
        t = (v9 + ONE_W) >>> 1;
        if (t > SAT_HI) begin
            c = SAT_HI;
        end else if (t < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = t;
        end
        return c[PT_BITS-1:0];
    endfunction

endpackage

// File: design/sppg_ifs.sv
// ----------------------------------------------------------------------------
// sppg channel interfaces
// Shape command channel and path element channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sppg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic [30:0] span_w;
    logic [30:0] span_h;
    logic [30:0] corner_radius_x;
    logic [30:0] corner_radius_y;

    modport source (
        output valid, op, left, top, span_w, span_h, corner_radius_x, corner_radius_y,
        input  ready
    );
    modport sink (
        input  valid, op, left, top, span_w, span_h, corner_radius_x, corner_radius_y,
        output ready
    );
endinterface

interface sppg_elem_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        last;

    modport source (
        output valid, kind, point_x, point_y, last,
        input  ready
    );
    modport sink (
        input  valid, kind, point_x, point_y, last,
        output ready
    );
endinterface

// File: design/sppg_front.sv
// ----------------------------------------------------------------------------
// sppg_front: command intake and point preparation
// Two register stages: clamp radii and form edges, then kappa multiply and
// edge-plus-radius sums; the last offsets and saturation feed the queue.
// ----------------------------------------------------------------------------
module sppg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sppg_cmd_if.sink             i_cmd,
    output logic                 o_job_valid,
    output sppg_pkg::t_job       o_job,
    input  logic                 i_job_ready
);

    localparam int W = sppg_pkg::WIDE;
    localparam int R = sppg_pkg::RAD_BITS;

    // stage 1
    logic                   r_s1_v;
    sppg_pkg::t_op          r_s1_op;
    logic signed [W-1:0]    r_s1_l9, r_s1_t9, r_s1_r9, r_s1_b9;
    logic [R-1:0]           r_s1_rx, r_s1_ry;
    sppg_pkg::t_op          n_s1_op;
    logic signed [W-1:0]    n_s1_l9, n_s1_t9, n_s1_r9, n_s1_b9;
    logic [R-1:0]           n_s1_rx, n_s1_ry;
    logic [R:0]             dbl_rx, dbl_ry;

    // stage 2
    logic                   r_s2_v;
    sppg_pkg::t_op          r_s2_op;
    logic signed [W-1:0]    r_s2_xlo, r_s2_xlr, r_s2_xhr, r_s2_xhi;
    logic signed [W-1:0]    r_s2_ylo, r_s2_ylr, r_s2_yhr, r_s2_yhi;
    logic [R-1:0]           r_s2_ox, r_s2_oy;

    logic s1_adv, s2_adv, cmd_take;

    assign s2_adv      = !r_s2_v || i_job_ready;
    assign s1_adv      = !r_s1_v || s2_adv;
    assign i_cmd.ready = s1_adv;
    assign cmd_take    = i_cmd.valid && s1_adv;

    always_comb begin
        n_s1_op = sppg_pkg::t_op'(i_cmd.op);
        n_s1_l9 = W'(i_cmd.left) <<< 1;
        n_s1_t9 = W'(i_cmd.top) <<< 1;
        n_s1_r9 = n_s1_l9 + (W'(i_cmd.span_w) <<< 1);
        n_s1_b9 = n_s1_t9 + (W'(i_cmd.span_h) <<< 1);
        dbl_rx  = {i_cmd.corner_radius_x, 1'b0};
        dbl_ry  = {i_cmd.corner_radius_y, 1'b0};
        // ellipse radius is the half span; corner radius clamps to it
        if (n_s1_op == sppg_pkg::OP_ELLIPSE || dbl_rx >= {1'b0, i_cmd.span_w}) begin
            n_s1_rx = i_cmd.span_w;
        end else begin
            n_s1_rx = dbl_rx[R-1:0];
        end
        if (n_s1_op == sppg_pkg::OP_ELLIPSE || dbl_ry >= {1'b0, i_cmd.span_h}) begin
            n_s1_ry = i_cmd.span_h;
        end else begin
            n_s1_ry = dbl_ry[R-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            // drop the unused shape code at intake
            if (s1_adv) begin
                r_s1_v <= cmd_take && (n_s1_op != sppg_pkg::OP_NONE);
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_op <= n_s1_op;
            r_s1_l9 <= n_s1_l9;
            r_s1_t9 <= n_s1_t9;
            r_s1_r9 <= n_s1_r9;
            r_s1_b9 <= n_s1_b9;
            r_s1_rx <= n_s1_rx;
            r_s1_ry <= n_s1_ry;
        end
        if (s2_adv) begin
            r_s2_op  <= r_s1_op;
            r_s2_xlo <= r_s1_l9;
            r_s2_xlr <= r_s1_l9 + W'(r_s1_rx);
            r_s2_xhr <= r_s1_r9 - W'(r_s1_rx);
            r_s2_xhi <= r_s1_r9;
            r_s2_ylo <= r_s1_t9;
            r_s2_ylr <= r_s1_t9 + W'(r_s1_ry);
            r_s2_yhr <= r_s1_b9 - W'(r_s1_ry);
            r_s2_yhi <= r_s1_b9;
            r_s2_ox  <= sppg_pkg::kap_mul(r_s1_rx);
            r_s2_oy  <= sppg_pkg::kap_mul(r_s1_ry);
        end
    end

    always_comb begin
        o_job.op = r_s2_op;
        o_job.px[sppg_pkg::SEL_LO]     = sppg_pkg::sat_q8(r_s2_xlo);
        o_job.px[sppg_pkg::SEL_LO_IN]  = sppg_pkg::sat_q8(r_s2_xlr - W'(r_s2_ox));
        o_job.px[sppg_pkg::SEL_LO_RAD] = sppg_pkg::sat_q8(r_s2_xlr);
        o_job.px[sppg_pkg::SEL_HI_RAD] = sppg_pkg::sat_q8(r_s2_xhr);
        o_job.px[sppg_pkg::SEL_HI_IN]  = sppg_pkg::sat_q8(r_s2_xhr + W'(r_s2_ox));
        o_job.px[sppg_pkg::SEL_HI]     = sppg_pkg::sat_q8(r_s2_xhi);
        o_job.py[sppg_pkg::SEL_LO]     = sppg_pkg::sat_q8(r_s2_ylo);
        o_job.py[sppg_pkg::SEL_LO_IN]  = sppg_pkg::sat_q8(r_s2_ylr - W'(r_s2_oy));
        o_job.py[sppg_pkg::SEL_LO_RAD] = sppg_pkg::sat_q8(r_s2_ylr);
        o_job.py[sppg_pkg::SEL_HI_RAD] = sppg_pkg::sat_q8(r_s2_yhr);
        o_job.py[sppg_pkg::SEL_HI_IN]  = sppg_pkg::sat_q8(r_s2_yhr + W'(r_s2_oy));
        o_job.py[sppg_pkg::SEL_HI]     = sppg_pkg::sat_q8(r_s2_yhi);
    end

    assign o_job_valid = r_s2_v;

endmodule

// File: design/sppg_queue.sv
// ----------------------------------------------------------------------------
// sppg_queue: short job queue between front and back
// Register-based FIFO of prepared shapes; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module sppg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sppg_pkg::t_job  i_push_job,
    output logic            o_push_ready,
    output logic            o_head_valid,
    output sppg_pkg::t_job  o_head_job,
    input  logic            i_pop
);

    localparam int D = sppg_pkg::Q_DEPTH;

    sppg_pkg::t_job                      r_mem [D];
    logic [sppg_pkg::QPTR_BITS-1:0]      r_wr_ptr, r_rd_ptr;
    logic [sppg_pkg::QCNT_BITS-1:0]      r_count;
    logic                                do_push, do_pop;

    assign o_push_ready = (r_count != sppg_pkg::QCNT_BITS'(D));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == sppg_pkg::QPTR_BITS'(D - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == sppg_pkg::QPTR_BITS'(D - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// File: design/sppg_back.sv
// ----------------------------------------------------------------------------
// sppg_back: path element sequencer
// Steps through the element table of the head shape into the output register,
// one element per cycle barring stalls, and releases the shape with its last element.
// ----------------------------------------------------------------------------
module sppg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  sppg_pkg::t_job  i_head_job,
    output logic            o_pop,
    sppg_elem_if.source     o_elem
);

    logic [sppg_pkg::IDX_BITS-1:0] r_idx, n_idx;
    logic                          r_o_valid;
    sppg_pkg::t_kind               r_o_kind;
    logic [sppg_pkg::PT_BITS-1:0]  r_o_x, r_o_y;
    logic                          r_o_last;

    sppg_pkg::t_step               step;
    logic                          is_last, load, emit;

    assign load    = !r_o_valid || o_elem.ready;
    assign emit    = load && i_head_valid;
    assign step    = sppg_pkg::STEP_TAB[i_head_job.op][r_idx];
    assign is_last = (r_idx == sppg_pkg::LAST_IDX[i_head_job.op]);
    assign o_pop   = emit && is_last;
    assign n_idx   = is_last ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx <= n_idx;
            end
            if (load) begin
                r_o_valid <= i_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind <= step.kind;
            r_o_x    <= i_head_job.px[step.xs];
            r_o_y    <= i_head_job.py[step.ys];
            r_o_last <= is_last;
        end
    end

    assign o_elem.valid   = r_o_valid;
    assign o_elem.kind    = r_o_kind;
    assign o_elem.point_x = r_o_x;
    assign o_elem.point_y = r_o_y;
    assign o_elem.last    = r_o_last;

endmodule

// File: design/shape_to_path_generator_unit.sv
// ----------------------------------------------------------------------------
// shape_to_path_generator_unit: shape command to path element stream
// The first element of a shape passes the front stages, the job queue and the
// output register of the back. One element per cycle on o_elem while it is ready;
//   a shape gives 5 (rectangle), 16 (rounded rectangle) or 14 (ellipse) elements.
// Commands enter at one per cycle until the 2-deep job queue and the front stages fill.
// Reset (synchronous, active low) empties the pipeline, queue and sequencer.
// ----------------------------------------------------------------------------
module shape_to_path_generator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sppg_cmd_if.sink     i_cmd,
    sppg_elem_if.source  o_elem
);

    // Front to queue: one prepared shape per transaction
    logic           job_valid;
    logic           job_ready;
    sppg_pkg::t_job job;

    // Queue to back: head of queue and its release
    logic           head_valid;
    sppg_pkg::t_job head_job;
    logic           head_pop;

    // Front: take the command, clamp the corner radii (an ellipse uses its
    // half spans as radii), run the kappa multiply, then form and saturate
    // the six candidate coordinates on each axis. Commands with the unused
    // shape code are taken and dropped here, giving no elements.
    sppg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    // Queue: hold prepared shapes so the front keeps taking commands while
    // the back is still streaming the elements of an earlier shape.
    sppg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (job_valid),
        .i_push_job   (job),
        .o_push_ready (job_ready),
        .o_head_valid (head_valid),
        .o_head_job   (head_job),
        .i_pop        (head_pop)
    );

    // Back: walk the element table of the head shape, pick the point for
    // each element from the prepared candidates, flag the last one and
    // advance to the next shape with no gap cycle. A stalled output holds
    // the element in its register.
    sppg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_job   (head_job),
        .o_pop        (head_pop),
        .o_elem       (o_elem)
    );

endmodule
